/* sv/symmetric_fir_lowpass_23tap_defines.svh */
// Assertion helpers shared by the filter modules.
// Each macro expects clk and arst_n in scope.
`ifndef SYMMETRIC_FIR_LOWPASS_23TAP_DEFINES_SVH
`define SYMMETRIC_FIR_LOWPASS_23TAP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SFL_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// Check a consequence in the cycle after its cause.
`define SFL_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

/* sv/sfl_pkg.sv */
package sfl_pkg;

	localparam int RING_DEPTH_DEF = 32;
	localparam int SAMPLE_W       = 16;
	localparam int PAIR_W         = SAMPLE_W + 1;
	localparam int COEF_W         = 14;
	localparam int PROD_W         = PAIR_W + COEF_W;
	localparam int ACC_W          = 32;
	localparam int OUT_SHIFT      = 15;
	localparam int NUM_COEF       = 12;
	localparam int CENTRE_TAP     = NUM_COEF - 1;
	localparam int LAST_TAP       = 2 * CENTRE_TAP;
	localparam int TAP_W          = 4;
	// Register stages between the ring read and the accumulator.
	localparam int PIPE_DEPTH     = 3;

	typedef logic [TAP_W-1:0] tap_idx_t;

	typedef struct packed {
		logic     write;
		logic     issue;
		tap_idx_t tap;
		logic     load_out;
	} sfl_cmd_t;

	typedef struct packed {
		logic out_full;
	} sfl_sts_t;

	function automatic logic signed [COEF_W-1:0] coef_of(input tap_idx_t k);
		logic signed [COEF_W-1:0] c;
		unique case (k)
			4'd0:    c = 14'sd172;
			4'd1:    c = 14'sd321;
			4'd2:    c = 14'sd579;
			4'd3:    c = 14'sd927;
			4'd4:    c = 14'sd1360;
			4'd5:    c = 14'sd1858;
			4'd6:    c = 14'sd2390;
			4'd7:    c = 14'sd2916;
			4'd8:    c = 14'sd3391;
			4'd9:    c = 14'sd3768;
			4'd10:   c = 14'sd4012;
			4'd11:   c = 14'sd4096;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* sv/sfl_ctrl.sv */
`include "symmetric_fir_lowpass_23tap_defines.svh"

module sfl_ctrl
	import sfl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output sfl_cmd_t cmd,
	input  sfl_sts_t sts
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	tap_idx_t   cnt_q;
	tap_idx_t   cnt_d;
	logic       accept;

	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign cmd.write    = accept;
	assign cmd.issue    = (state_q == ST_RUN);
	assign cmd.tap      = cnt_q;
	assign cmd.load_out = (state_q == ST_DONE) && !sts.out_full;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
					cnt_d   = '0;
				end
			end
			ST_RUN: begin
				if (cnt_q == tap_idx_t'(CENTRE_TAP)) begin
					state_d = ST_DRAIN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + tap_idx_t'(1);
				end
			end
			ST_DRAIN: begin
				if (cnt_q == tap_idx_t'(PIPE_DEPTH - 1)) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + tap_idx_t'(1);
				end
			end
			ST_DONE: begin
				// hold the result until the output register is free
				if (!sts.out_full) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	`SFL_ASSERT_NEXT(a_write_starts_run, cmd.write, state_q == ST_RUN && cnt_q == '0, "run did not start after write")
	`SFL_ASSERT_NEXT(a_centre_ends_run, state_q == ST_RUN && cnt_q == tap_idx_t'(CENTRE_TAP), state_q == ST_DRAIN && cnt_q == '0, "run did not stop at centre tap")
	`SFL_ASSERT_NOW(a_tap_in_range, cmd.issue, cnt_q <= tap_idx_t'(CENTRE_TAP), "tap index past centre")

endmodule

/* sv/sfl_dp.sv */
`include "symmetric_fir_lowpass_23tap_defines.svh"

module sfl_dp
	import sfl_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  sfl_cmd_t                   cmd,
	output sfl_sts_t                   sts,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] filtered_out
);

	localparam int AW   = $clog2(RING_DEPTH);
	localparam int SH_W = ACC_W - OUT_SHIFT;
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0]      vld_q;
	logic [AW-1:0]              wp_q;
	logic [AW-1:0]              base_q;
	logic [AW-1:0]              addr_a;
	logic [AW-1:0]              addr_b;

	logic signed [SAMPLE_W-1:0] rd_a_s1;
	logic signed [SAMPLE_W-1:0] rd_b_s1;
	logic                       va_s1;
	logic                       vb_s1;
	tap_idx_t                   tap_s1;
	logic                       act_s1;

	logic signed [PAIR_W-1:0]   term_a;
	logic signed [PAIR_W-1:0]   term_b;
	logic signed [PAIR_W-1:0]   pair_s2;
	logic signed [COEF_W-1:0]   coef_s2;
	logic                       act_s2;

	logic signed [PROD_W-1:0]   prod_s3;
	logic                       act_s3;

	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SH_W-1:0]     shifted;
	logic signed [SAMPLE_W-1:0] sat_val;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic                       out_valid_q;

	// tap k and its mirror 22-k, both counted back from the newest sample
	assign addr_a = base_q - AW'(cmd.tap);
	assign addr_b = base_q - AW'(LAST_TAP) + AW'(cmd.tap);

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			ring_mem[wp_q] <= sample_in;
		end
		rd_a_s1 <= ring_mem[addr_a];
		rd_b_s1 <= ring_mem[addr_b];
		tap_s1  <= cmd.tap;
	end

	// entries never written since reset read as zero
	always_comb begin
		term_a = va_s1 ? PAIR_W'(rd_a_s1) : PAIR_W'(0);
		term_b = vb_s1 ? PAIR_W'(rd_b_s1) : PAIR_W'(0);
	end

	always_ff @(posedge clk) begin
		pair_s2 <= term_a + term_b;
		coef_s2 <= coef_of(tap_s1);
		prod_s3 <= pair_s2 * coef_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			wp_q   <= '0;
			base_q <= '0;
			va_s1  <= 1'b0;
			vb_s1  <= 1'b0;
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
			act_s3 <= 1'b0;
		end else begin
			if (cmd.write) begin
				vld_q[wp_q] <= 1'b1;
				base_q      <= wp_q;
				wp_q        <= wp_q + AW'(1);
			end
			va_s1  <= vld_q[addr_a];
			// the centre tap has no partner
			vb_s1  <= vld_q[addr_b] && (cmd.tap != tap_idx_t'(CENTRE_TAP));
			act_s1 <= cmd.issue;
			act_s2 <= act_s1;
			act_s3 <= act_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			acc_q <= '0;
		end else if (act_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	assign shifted = acc_q[ACC_W-1:OUT_SHIFT];

	always_comb begin
		if (shifted[SH_W-1] != shifted[SH_W-2]) begin
			sat_val = shifted[SH_W-1] ? SAT_MIN : SAT_MAX;
		end else begin
			sat_val = shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			filtered_q <= sat_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered_out = filtered_q;
	assign sts.out_full = out_valid_q && out_stall;

	`SFL_ASSERT_NOW(a_load_after_drain, cmd.load_out, !act_s1 && !act_s2 && !act_s3, "result loaded before pipeline drained")
	`SFL_ASSERT_NOW(a_write_when_empty, cmd.write, !act_s1 && !act_s2 && !act_s3, "sample written while pipeline busy")
	`SFL_ASSERT_NEXT(a_write_clears_acc, cmd.write, acc_q == '0, "accumulator not cleared on new sample")

endmodule

/* sv/symmetric_fir_lowpass_23tap.sv */
// 23-tap symmetric low-pass FIR over signed 16-bit samples.
// Input channel: in_valid / in_stall carry sample_in; a transaction completes
// on a rising clk edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry filtered_out, one result per
// input transaction, in order.
// Each sample is written into a 32-entry ring, then one shared multiplier
// walks the 12 coefficients, one pair sum per cycle, through a three-stage
// read / pair-add / multiply pipeline into a 32-bit accumulator.
// out_valid rises when the result is loaded into the output register, after
// the coefficient passes and the drain. No new sample is taken until the 12
// multiplier passes, pipeline fill and result load end; in_stall stays high.
// Stall: the finished result waits in the output register; a new sample can
// be taken while it waits, but its own result holds until the register frees.
// Reset (arst_n low, asynchronous): the ring reads as all zero, the write
// position returns to zero and no result is pending.
module symmetric_fir_lowpass_23tap
	import sfl_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] filtered_out
);

	sfl_cmd_t cmd;
	sfl_sts_t sts;

	// sequence the write, the 12 coefficient passes, the drain and the load
	sfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// ring, pair adder, multiplier, accumulator and output register
	sfl_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_in    (sample_in),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_out (filtered_out)
	);

endmodule
